// File: rtl/uerm_pkg.sv
// Shared widths, register index codes and range-scaling constants for the
// ultrasonic echo range meter. No dependencies.

package uerm_pkg;

	// Accumulated pulse width and tick counter widths.
	localparam int WIDTH_BITS      = 18;
	localparam int TICK_COUNT_BITS = 20;

	// Configuration register widths.
	localparam int TRIG_BITS      = 8;
	localparam int RISE_TO_BITS   = 20;
	localparam int ECHO_TO_BITS   = 16;
	localparam int STEP_BITS      = 4;
	localparam int HOLD_BITS      = 20;
	localparam int CFG_DATA_BITS  = 20;
	localparam int CFG_INDEX_BITS = 3;
	localparam int RANGE_BITS     = 16;

	// Reset values of the configuration registers.
	localparam logic [TRIG_BITS-1:0]    TRIG_RESET    = TRIG_BITS'(20);
	localparam logic [RISE_TO_BITS-1:0] RISE_TO_RESET = RISE_TO_BITS'(100000);
	localparam logic [ECHO_TO_BITS-1:0] ECHO_TO_RESET = ECHO_TO_BITS'(60000);
	localparam logic [STEP_BITS-1:0]    STEP_RESET    = STEP_BITS'(4);
	localparam logic [HOLD_BITS-1:0]    HOLD_RESET    = HOLD_BITS'(1000000);

	// Range is floor(17 * width / 100). The product 17 * width is divided by
	// 100 through a reciprocal multiply; the reciprocal error stays below
	// 2^(RECIP_SHIFT - SCALED_BITS), which keeps the quotient exact.
	localparam int SCALED_BITS = WIDTH_BITS + 5;
	localparam int RECIP_SHIFT = SCALED_BITS + 7;
	localparam int RECIP_BITS  = RECIP_SHIFT - 6;
	localparam int PROD_BITS   = SCALED_BITS + RECIP_BITS;
	localparam int QUOT_BITS   = PROD_BITS - RECIP_SHIFT;
	localparam longint unsigned RECIP_VALUE =
		((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;

	typedef logic [WIDTH_BITS-1:0]      width_t;
	typedef logic [TICK_COUNT_BITS-1:0] count_t;
	typedef logic [RANGE_BITS-1:0]      range_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TRIGGER_TICKS = 3'd0,
		REG_RISE_TIMEOUT  = 3'd1,
		REG_ECHO_TIMEOUT  = 3'd2,
		REG_WIDTH_STEP    = 3'd3,
		REG_HOLDOFF_TICKS = 3'd4
	} cfg_index_t;

endpackage

// File: rtl/uerm_tick_if.sv
// Input channel: one timing tick carrying the sampled echo level.
// Depends on nothing.

interface uerm_tick_if;
	logic valid;
	logic ready;
	logic echo_level;

	modport source (output valid, output echo_level, input ready);
	modport sink (input valid, input echo_level, output ready);
endinterface

// File: rtl/uerm_result_if.sv
// Output channel: one result per tick with trigger drive and report fields.
// Depends on uerm_pkg for the field types.

interface uerm_result_if;
	logic             valid;
	logic             ready;
	logic             trigger_level;
	logic             report_valid;
	uerm_pkg::width_t echo_width;
	uerm_pkg::range_t range_mm;
	logic             no_echo;
	logic             echo_too_long;

	modport source (output valid, output trigger_level, output report_valid,
		output echo_width, output range_mm, output no_echo, output echo_too_long,
		input ready);
	modport sink (input valid, input trigger_level, input report_valid,
		input echo_width, input range_mm, input no_echo, input echo_too_long,
		output ready);
endinterface

// File: rtl/uerm_range.sv
// Converts a pulse width into range: floor(17 * width / 100), saturated.
// Depends on uerm_pkg for widths and the reciprocal constant.

module uerm_range (
	input  uerm_pkg::width_t echo_width,
	output uerm_pkg::range_t range_mm
);
	localparam logic [uerm_pkg::RECIP_BITS-1:0] RECIP =
		uerm_pkg::RECIP_BITS'(uerm_pkg::RECIP_VALUE);

	logic [uerm_pkg::SCALED_BITS-1:0] scaled;
	logic [uerm_pkg::PROD_BITS-1:0]   prod;
	logic [uerm_pkg::QUOT_BITS-1:0]   quot;

	// 17 * width as a shift and add.
	assign scaled = (uerm_pkg::SCALED_BITS'(echo_width) << 4)
		+ uerm_pkg::SCALED_BITS'(echo_width);
	assign prod = uerm_pkg::PROD_BITS'(scaled) * uerm_pkg::PROD_BITS'(RECIP);
	assign quot = prod[uerm_pkg::PROD_BITS-1:uerm_pkg::RECIP_SHIFT];

	always_comb begin
		if (quot > uerm_pkg::QUOT_BITS'({uerm_pkg::RANGE_BITS{1'b1}})) begin
			range_mm = '1;
		end else begin
			range_mm = uerm_pkg::RANGE_BITS'(quot);
		end
	end
endmodule

// File: rtl/ultrasonic_echo_range_meter_core.sv
// Top level of the ultrasonic echo range meter: ranging sequencer, config
// registers and result register. Depends on uerm_pkg, uerm_tick_if,
// uerm_result_if and uerm_range.
//
//   Channel   Dir  Handshake       Contents
//   tick      in   valid/ready     echo_level, one request per timing tick
//   result    out  valid/ready     trigger, report flag, width, range, flags
//   cfg_*     in   cfg_we only     register index and write data
//
// Every accepted tick request yields exactly one result request. The next
// state and the result are computed combinationally from the registered state
// and the incoming echo level, and land in the result register together.
// Throughput is one tick per clock unless a result stall holds it; a result
// appears in the cycle after its tick is accepted. A new tick is accepted whenever the result
// register is empty or is being emptied in the same cycle, so a stall on
// the result side holds the tick side only while a result is waiting.
// Reset brings the sequencer to the start of the trigger phase with the
// counters cleared and the configuration registers at their defaults.

module ultrasonic_echo_range_meter_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [uerm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [uerm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	uerm_tick_if.sink                             tick,
	uerm_result_if.source                         result
);
	// Ranging cycle: trigger pulse, wait for echo rise, measure the echo
	// width, then hold off before the next trigger.
	typedef enum logic [1:0] {
		PH_TRIG = 2'd0,
		PH_RISE = 2'd1,
		PH_MEAS = 2'd2,
		PH_HOLD = 2'd3
	} phase_t;

	// Configuration registers.
	logic [uerm_pkg::TRIG_BITS-1:0]    trig_ticks_q;
	logic [uerm_pkg::RISE_TO_BITS-1:0] rise_to_q;
	logic [uerm_pkg::ECHO_TO_BITS-1:0] echo_to_q;
	logic [uerm_pkg::STEP_BITS-1:0]    step_q;
	logic [uerm_pkg::HOLD_BITS-1:0]    hold_q;

	// Sequencer state.
	phase_t           phase_q;
	uerm_pkg::count_t count_q;
	uerm_pkg::width_t wsum_q;
	logic             missed_q;

	// Result register.
	logic             res_valid_q;
	logic             trig_out_q;
	logic             report_q;
	uerm_pkg::width_t width_out_q;
	uerm_pkg::range_t range_out_q;
	logic             no_echo_q;
	logic             too_long_q;

	// Next-state and result logic.
	phase_t           phase_d;
	uerm_pkg::count_t count_d;
	uerm_pkg::width_t wsum_d;
	logic             missed_d;
	logic             trig_d;
	logic             report_d;
	logic             no_echo_d;
	logic             too_long_d;
	uerm_pkg::width_t rep_width;
	uerm_pkg::range_t rep_range;

	uerm_pkg::count_t count_inc;
	uerm_pkg::count_t meas_count;
	uerm_pkg::width_t meas_width;
	logic [uerm_pkg::WIDTH_BITS:0] width_sum_wide;
	uerm_pkg::count_t trig_lim;
	uerm_pkg::count_t rise_lim;
	uerm_pkg::count_t echo_lim;
	uerm_pkg::count_t hold_lim;
	phase_t           after_report;
	logic             accept;

	assign accept     = tick.valid && tick.ready;
	assign tick.ready = !res_valid_q || result.ready;

	// A zero limit behaves as a limit of one for trigger, rise and echo.
	assign trig_lim = (trig_ticks_q == '0) ? uerm_pkg::count_t'(1)
		: uerm_pkg::count_t'(trig_ticks_q);
	assign rise_lim = (rise_to_q == '0) ? uerm_pkg::count_t'(1)
		: uerm_pkg::count_t'(rise_to_q);
	assign echo_lim = (echo_to_q == '0) ? uerm_pkg::count_t'(1)
		: uerm_pkg::count_t'(echo_to_q);
	assign hold_lim = uerm_pkg::count_t'(hold_q);

	assign count_inc    = count_q + uerm_pkg::count_t'(1);
	assign after_report = (hold_q == '0) ? PH_TRIG : PH_HOLD;

	// A measured high tick: the rise wait starts the count afresh, the
	// measure phase continues it. The width saturates at all ones.
	assign meas_count     = (phase_q == PH_RISE) ? uerm_pkg::count_t'(1) : count_inc;
	assign width_sum_wide = {1'b0, wsum_q} + (uerm_pkg::WIDTH_BITS + 1)'(step_q);
	assign meas_width     = width_sum_wide[uerm_pkg::WIDTH_BITS] ? '1
		: width_sum_wide[uerm_pkg::WIDTH_BITS-1:0];

	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		wsum_d     = wsum_q;
		missed_d   = missed_q;
		trig_d     = 1'b0;
		report_d   = 1'b0;
		no_echo_d  = 1'b0;
		too_long_d = 1'b0;

		case (phase_q)
			PH_RISE, PH_MEAS: begin
				if (tick.echo_level) begin
					wsum_d  = meas_width;
					count_d = meas_count;
					phase_d = PH_MEAS;
					if (meas_count >= echo_lim) begin
						report_d   = 1'b1;
						too_long_d = 1'b1;
						no_echo_d  = missed_q;
						count_d    = '0;
						phase_d    = after_report;
					end
				end else if (phase_q == PH_MEAS) begin
					// The first low tick ends the measurement.
					report_d  = 1'b1;
					no_echo_d = missed_q;
					count_d   = '0;
					phase_d   = after_report;
				end else begin
					count_d = count_inc;
					if (count_inc >= rise_lim) begin
						missed_d  = 1'b1;
						wsum_d    = '0;
						report_d  = 1'b1;
						no_echo_d = 1'b1;
						count_d   = '0;
						phase_d   = after_report;
					end
				end
			end
			PH_HOLD: begin
				count_d = count_inc;
				if (count_inc >= hold_lim) begin
					phase_d = PH_TRIG;
					count_d = '0;
				end
			end
			default: begin
				// Trigger phase; the first tick of it clears the measurement.
				if (count_q == '0) begin
					wsum_d   = '0;
					missed_d = 1'b0;
				end
				trig_d  = 1'b1;
				count_d = count_inc;
				if (count_inc >= trig_lim) begin
					phase_d = PH_RISE;
					count_d = '0;
				end
			end
		endcase
	end

	// Fields of a report carry the width as it stands after this tick and
	// read as zero on ticks without a report.
	assign rep_width = report_d ? wsum_d : '0;

	uerm_range u_range (
		.echo_width (rep_width),
		.range_mm   (rep_range)
	);

	// Configuration writes; an index outside the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q <= uerm_pkg::TRIG_RESET;
			rise_to_q    <= uerm_pkg::RISE_TO_RESET;
			echo_to_q    <= uerm_pkg::ECHO_TO_RESET;
			step_q       <= uerm_pkg::STEP_RESET;
			hold_q       <= uerm_pkg::HOLD_RESET;
		end else if (cfg_we) begin
			case (uerm_pkg::cfg_index_t'(cfg_index))
				uerm_pkg::REG_TRIGGER_TICKS: trig_ticks_q <= cfg_data[uerm_pkg::TRIG_BITS-1:0];
				uerm_pkg::REG_RISE_TIMEOUT:  rise_to_q    <= cfg_data[uerm_pkg::RISE_TO_BITS-1:0];
				uerm_pkg::REG_ECHO_TIMEOUT:  echo_to_q    <= cfg_data[uerm_pkg::ECHO_TO_BITS-1:0];
				uerm_pkg::REG_WIDTH_STEP:    step_q       <= cfg_data[uerm_pkg::STEP_BITS-1:0];
				uerm_pkg::REG_HOLDOFF_TICKS: hold_q       <= cfg_data[uerm_pkg::HOLD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer state and the result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TRIG;
			count_q     <= '0;
			wsum_q      <= '0;
			missed_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				count_q     <= count_d;
				wsum_q      <= wsum_d;
				missed_q    <= missed_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; loaded only when a tick is accepted.
	always_ff @(posedge clk) begin
		if (accept) begin
			trig_out_q  <= trig_d;
			report_q    <= report_d;
			width_out_q <= rep_width;
			range_out_q <= rep_range;
			no_echo_q   <= no_echo_d;
			too_long_q  <= too_long_d;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.trigger_level = trig_out_q;
	assign result.report_valid  = report_q;
	assign result.echo_width    = width_out_q;
	assign result.range_mm      = range_out_q;
	assign result.no_echo       = no_echo_q;
	assign result.echo_too_long = too_long_q;
endmodule

// File: tb/ultrasonic_echo_range_meter_core_tb.sv
// Self-checking testbench for ultrasonic_echo_range_meter_core: drives echo ticks and
// register writes, predicts every result in step and compares it field by field.
// Depends on uerm_pkg, uerm_tick_if, uerm_result_if and the core RTL.

module ultrasonic_echo_range_meter_core_tb;
	import uerm_pkg::*;

	// The run stops here no matter what. The slowest legal run is about fifteen
	// hundred ticks, each waiting out the longest sender gap and receiver stall.
	localparam int LIMIT_CYCLES = 4_000_000;

	// Register indexes above the last defined register are decoded as no-ops.
	localparam int UNUSED_INDEX_LO = int'(REG_HOLDOFF_TICKS) + 1;
	localparam int UNUSED_INDEX_HI = (1 << CFG_INDEX_BITS) - 1;

	typedef enum logic [2:0] {
		RANGING_TRIGGER,
		RANGING_RISE_WAIT,
		RANGING_MEASURE,
		RANGING_HOLDOFF
	} ranging_phase_t;

	// One result as the block presents it on the result channel.
	typedef struct packed {
		logic   trigger_level;
		logic   report_valid;
		width_t echo_width;
		range_t range_mm;
		logic   no_echo;
		logic   echo_too_long;
	} echo_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	uerm_tick_if   tick_ch();
	uerm_result_if result_ch();

	ultrasonic_echo_range_meter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick      (tick_ch),
		.result    (result_ch)
	);

	always #6 clk = ~clk;

	// Our own copy of the ranging sequencer and of the configuration registers.
	// The registers are updated when the write is issued; that is safe because
	// writes only happen while no tick is in flight.
	ranging_phase_t          ranging_phase;
	count_t                  tick_cnt;
	width_t                  width_acc;
	logic                    rise_missed_flag;
	logic [TRIG_BITS-1:0]    trig_cfg;
	logic [RISE_TO_BITS-1:0] rise_to_cfg;
	logic [ECHO_TO_BITS-1:0] echo_to_cfg;
	logic [STEP_BITS-1:0]    step_cfg;
	logic [HOLD_BITS-1:0]    hold_cfg;

	// Echo levels waiting to be sent, and results predicted but not yet seen.
	logic         pending_echo[$];
	echo_result_t echo_expect[$];
	echo_result_t oldest_expect;

	int gap_pct   = 0;
	int stall_pct = 0;
	int gap_left  = 0;
	int stall_left = 0;
	int cycle_count = 0;

	int failures        = 0;
	int results_checked = 0;
	int reports_seen    = 0;
	int no_echo_seen    = 0;
	int too_long_seen   = 0;
	int saturated_seen  = 0;
	int settings_used   = 1;

	// A zero timeout or trigger length behaves as one tick.
	function automatic int unsigned at_least_one(input int unsigned v);
		return (v == 0) ? 1 : v;
	endfunction

	// Closes a measurement: latches width, range and flags into the result and
	// moves on to the hold-off, or straight to a new trigger when it is zero.
	function automatic void finish_measurement(inout echo_result_t r, input logic too_long);
		int unsigned scaled;
		scaled = ((32'(width_acc) * 32'd34) / 32'd100) >> 1;
		r.report_valid  = 1'b1;
		r.echo_width    = width_acc;
		r.range_mm      = (scaled > 32'hFFFF) ? 16'hFFFF : RANGE_BITS'(scaled);
		r.no_echo       = rise_missed_flag;
		r.echo_too_long = too_long;
		tick_cnt        = '0;
		ranging_phase   = (hold_cfg == '0) ? RANGING_TRIGGER : RANGING_HOLDOFF;
	endfunction

	// One tick of high echo while measuring; the width saturates at all ones.
	function automatic void accumulate_high(inout echo_result_t r);
		logic [WIDTH_BITS:0] sum;
		sum = {1'b0, width_acc} + (WIDTH_BITS+1)'(step_cfg);
		width_acc = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
		tick_cnt = tick_cnt + 1'b1;
		if (tick_cnt >= at_least_one(echo_to_cfg))
			finish_measurement(r, 1'b1);
	endfunction

	// Advances the sequencer by one accepted tick and returns its result.
	function automatic echo_result_t step_ranging(input logic echo);
		echo_result_t r;
		r = '0;
		case (ranging_phase)
		RANGING_RISE_WAIT: begin
			if (echo) begin
				ranging_phase = RANGING_MEASURE;
				tick_cnt = '0;
				accumulate_high(r);
			end else begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= at_least_one(rise_to_cfg)) begin
					rise_missed_flag = 1'b1;
					width_acc = '0;
					finish_measurement(r, 1'b0);
				end
			end
		end
		RANGING_MEASURE: begin
			if (echo)
				accumulate_high(r);
			else
				finish_measurement(r, 1'b0);
		end
		RANGING_HOLDOFF: begin
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= hold_cfg) begin
				ranging_phase = RANGING_TRIGGER;
				tick_cnt = '0;
			end
		end
		default: begin
			// The first trigger tick of a cycle clears the previous measurement.
			if (tick_cnt == '0) begin
				width_acc = '0;
				rise_missed_flag = 1'b0;
			end
			r.trigger_level = 1'b1;
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt >= at_least_one(trig_cfg)) begin
				ranging_phase = RANGING_RISE_WAIT;
				tick_cnt = '0;
			end
		end
		endcase
		return r;
	endfunction

	// Mostly no pause; otherwise a short one, and now and then a long one.
	function automatic int pick_pause(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(20, 8);
		return $urandom_range(3, 1);
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			failures++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Tick driver. The prediction is made at the edge where the request is
	// accepted, so the expectation is queued before its result can appear.
	// Gaps are inserted only after a request is taken or while valid is low,
	// so a request once raised stays up until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ch.valid      <= 1'b0;
			tick_ch.echo_level <= 1'b0;
			gap_left = 0;
		end else begin
			if (tick_ch.valid && tick_ch.ready)
				echo_expect.push_back(step_ranging(tick_ch.echo_level));
			if (!tick_ch.valid || tick_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					tick_ch.valid <= 1'b0;
				end else if (pending_echo.size() != 0) begin
					tick_ch.valid      <= 1'b1;
					tick_ch.echo_level <= pending_echo.pop_front();
					gap_left = pick_pause(gap_pct);
				end else begin
					tick_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor with random back-pressure. Every accepted result is held
	// against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (echo_expect.size() == 0) begin
					failures++;
					$display("%0t: result arrived with no tick outstanding", $time);
				end else begin
					oldest_expect = echo_expect.pop_front();
					compare_field("trigger_level", oldest_expect.trigger_level,
						result_ch.trigger_level);
					compare_field("report_valid", oldest_expect.report_valid,
						result_ch.report_valid);
					compare_field("echo_width", oldest_expect.echo_width,
						result_ch.echo_width);
					compare_field("range_mm", oldest_expect.range_mm, result_ch.range_mm);
					compare_field("no_echo", oldest_expect.no_echo, result_ch.no_echo);
					compare_field("echo_too_long", oldest_expect.echo_too_long,
						result_ch.echo_too_long);
					results_checked++;
					if (oldest_expect.report_valid) begin
						reports_seen++;
						if (oldest_expect.no_echo)
							no_echo_seen++;
						if (oldest_expect.echo_too_long)
							too_long_seen++;
						if (oldest_expect.echo_width == '1)
							saturated_seen++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				stall_left = pick_pause(stall_pct);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Blocks until every queued tick has been sent and every result checked,
	// then lets the registered pipeline settle.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_echo.size() != 0 || tick_ch.valid === 1'b1 || echo_expect.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// One register write; cfg_we stays high across back-to-back writes.
	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
		REG_TRIGGER_TICKS: trig_cfg    = data[TRIG_BITS-1:0];
		REG_RISE_TIMEOUT:  rise_to_cfg = data[RISE_TO_BITS-1:0];
		REG_ECHO_TIMEOUT:  echo_to_cfg = data[ECHO_TO_BITS-1:0];
		REG_WIDTH_STEP:    step_cfg    = data[STEP_BITS-1:0];
		REG_HOLDOFF_TICKS: hold_cfg    = data[HOLD_BITS-1:0];
		default: ;
		endcase
	endtask

	// Waits for the block to drain, then rewrites all five registers. Bits above
	// the trigger, echo timeout and step widths carry random junk that the block
	// must drop, and sometimes an undefined index is written too.
	task automatic apply_setting(input int unsigned trig, input int unsigned rise,
		input int unsigned echo_to, input int unsigned step, input int unsigned hold,
		input int idle_pct);
		wait_idle();
		write_register(REG_TRIGGER_TICKS, {12'($urandom), 8'(trig)});
		write_register(REG_RISE_TIMEOUT, 20'(rise));
		write_register(REG_ECHO_TIMEOUT, {4'($urandom), 16'(echo_to)});
		write_register(REG_WIDTH_STEP, {16'($urandom), 4'(step)});
		if ($urandom_range(2) == 0)
			write_register(CFG_INDEX_BITS'($urandom_range(UNUSED_INDEX_HI, UNUSED_INDEX_LO)),
				20'($urandom));
		write_register(REG_HOLDOFF_TICKS, 20'(hold));
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_pct   = idle_pct;
		stall_pct = idle_pct;
		settings_used++;
	endtask

	task automatic push_run(input logic level, input int count);
		repeat (count) pending_echo.push_back(level);
	endtask

	task automatic push_noise(input int count);
		repeat (count) pending_echo.push_back(1'($urandom));
	endtask

	// Random ranging traffic shaped by the current registers. Most of it is a
	// well-formed cycle: quiet line while waiting for the rise, an echo pulse,
	// the falling edge, then arbitrary levels through hold-off and trigger.
	// Now and then the wait or the pulse runs into its timeout, and a small
	// share is pure noise that lands wherever the sequencer happens to be.
	task automatic queue_echo_patterns(input int count);
		int made;
		int rise_len;
		int echo_len;
		int lows;
		int highs;
		int tail;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 15) begin
				lows = $urandom_range(4, 1);
				push_noise(lows);
				made += lows;
			end else begin
				rise_len = at_least_one(rise_to_cfg);
				echo_len = at_least_one(echo_to_cfg);
				lows  = ($urandom_range(9) == 0) ? rise_len : $urandom_range(rise_len - 1, 0);
				highs = ($urandom_range(7) == 0) ? echo_len + $urandom_range(2)
					: $urandom_range(echo_len, 1);
				tail  = hold_cfg + at_least_one(trig_cfg);
				push_run(1'b0, lows);
				push_run(1'b1, highs);
				push_run(1'b0, 1);
				push_noise(tail);
				made += lows + highs + 1 + tail;
			end
		end
	endtask

	initial begin
		int idle_pct;

		// Configuration inputs are known from time zero; the channel signals
		// are set by their own drivers while reset is held.
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;

		trig_cfg         = TRIG_RESET;
		rise_to_cfg      = RISE_TO_RESET;
		echo_to_cfg      = ECHO_TO_RESET;
		step_cfg         = STEP_RESET;
		hold_cfg         = HOLD_RESET;
		ranging_phase    = RANGING_TRIGGER;
		tick_cnt         = '0;
		width_acc        = '0;
		rise_missed_flag = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: a full trigger phase with the echo toggling (it must
		// be ignored), then a short pulse that reports a width of three steps.
		// The block is then left deep inside its long default hold-off.
		gap_pct   = 20;
		stall_pct = 20;
		for (int i = 0; i < 20; i++)
			pending_echo.push_back(1'(i));
		push_run(1'b0, 2);
		push_run(1'b1, 3);
		push_run(1'b0, 1);

		// All limits zero: each one acts as a single tick, and a report goes
		// straight back to triggering with no hold-off.
		apply_setting(0, 0, 0, 15, 0, 20);
		push_run(1'b1, 1);
		push_run(1'b0, 2);
		push_run(1'b1, 3);
		push_run(1'b0, 2);
		push_run(1'b1, 1);
		push_run(1'b0, 1);

		// Largest trigger, timeouts and step, first with no hold-off and then
		// with the largest hold-off, which the next setting cuts short.
		apply_setting(255, 1048575, 65535, 15, 0, 20);
		push_run(1'b1, 1);
		push_run(1'b0, 1);
		push_noise(255);
		push_run(1'b0, 6);
		push_run(1'b1, 5);
		push_run(1'b0, 1);
		apply_setting(255, 1048575, 65535, 15, 1048575, 20);
		push_noise(255);
		push_run(1'b0, 1);
		push_run(1'b1, 2);
		push_run(1'b0, 1);
		push_noise(10);

		// Random registers, kept small so that every phase of the cycle and
		// both timeouts come around often. Some settings run with no idling.
		for (int k = 0; k < 8; k++) begin
			case ($urandom_range(2))
			0: idle_pct = 0;
			1: idle_pct = 20;
			default: idle_pct = 45;
			endcase
			apply_setting($urandom_range(5, 0), $urandom_range(12, 0), $urandom_range(20, 0),
				$urandom_range(15, 0), $urandom_range(6, 0), idle_pct);
			queue_echo_patterns(100);
		end

		wait_idle();
		repeat (4) @(posedge clk);
		while (echo_expect.size() != 0) begin
			oldest_expect = echo_expect.pop_front();
			failures++;
			$display("%0t: expected result never arrived, expected %0h, actual none",
				$time, oldest_expect);
		end

		$display("Checked %0d results across %0d register settings.",
			results_checked, settings_used);
		$display("Saw %0d reports: %0d with no echo, %0d cut at the echo limit, %0d saturated.",
			reports_seen, no_echo_seen, too_long_seen, saturated_seen);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
